### hw/rtl/wind_rose_histogram_assert.svh
// Assertion macros for the wind rose histogram RTL.
// Used inside modules that have clk and arst_n in scope.
`ifndef WIND_ROSE_HISTOGRAM_ASSERT_SVH
`define WIND_ROSE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WRH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wind rose histogram: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WRH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wind rose histogram: next-cycle check failed");

`endif

### hw/rtl/wrh_pkg.sv
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
package wrh_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int NUM_SECTORS = 16;
	localparam int NUM_SPEED   = 5;
	localparam int NUM_BINS    = NUM_SECTORS * NUM_SPEED;
	localparam int BIN_IDX_W   = $clog2(NUM_BINS);

	localparam int OP_W    = 2;
	localparam int DIR_W   = 14;
	localparam int SPEED_W = 12;
	localparam int SEC_W   = 4;
	localparam int CLS_W   = 3;
	localparam int CNT_OUT_W = 32;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 2'd2;

	localparam logic [SPEED_W-1:0] LIMIT_LOW_RST  = 12'd80;
	localparam logic [SPEED_W-1:0] LIMIT_MID_RST  = 12'd240;
	localparam logic [SPEED_W-1:0] LIMIT_HIGH_RST = 12'd400;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CLS_W-1:0] CLS_ZERO  = 3'd0;
	localparam logic [CLS_W-1:0] CLS_LOW   = 3'd1;
	localparam logic [CLS_W-1:0] CLS_MID   = 3'd2;
	localparam logic [CLS_W-1:0] CLS_HIGH  = 3'd3;
	localparam logic [CLS_W-1:0] CLS_ABOVE = 3'd4;

	// 360 sixteenths of a degree per sector; 16 sectors = 5760.
	localparam logic [DIR_W-2:0] FULL_CIRCLE = 13'd5760;
	// floor(d / 360) == (d * 2913) >> 20 for all d < 5760
	localparam int RECIP_W = 12;
	localparam logic [RECIP_W-1:0] SECTOR_RECIP = 12'd2913;
	localparam int SECTOR_SHIFT = 20;
	localparam int PROD_W = (DIR_W - 1) + RECIP_W;

	typedef struct packed {
		logic capture;  // take input transfer into input registers
		logic calc;     // sector multiply, speed class, validity
		logic fetch;    // counter read
		logic update;   // counter write back, result load, clear
	} cmd_t;

	typedef struct packed {
		logic out_stall;  // result register full and not drained
	} stat_t;

endpackage

### hw/rtl/wrh_ctrl.sv
// Sequencer for the wind rose histogram: one item walks through
// capture, calc, fetch and update. Depends on wrh_pkg.
module wrh_ctrl
	import wrh_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output cmd_t  cmd,
	input  stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CALC   = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_CALC;
			ST_CALC:   state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_UPDATE;
			ST_UPDATE: if (!stat.out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready    = (state_q == ST_IDLE);
	assign cmd.capture = s_tready && s_tvalid;
	assign cmd.calc    = (state_q == ST_CALC);
	assign cmd.fetch   = (state_q == ST_FETCH);
	assign cmd.update  = (state_q == ST_UPDATE) && !stat.out_stall;

`include "wind_rose_histogram_assert.svh"

	`WRH_ASSERT_NEXT(a_accept_starts_calc, cmd.capture, state_q == ST_CALC)
	`WRH_ASSERT_NEXT(a_stall_holds_update, (state_q == ST_UPDATE) && stat.out_stall, state_q == ST_UPDATE)
	`WRH_ASSERT_IMPL(a_no_update_on_stall, cmd.update, !stat.out_stall)

endmodule

### hw/rtl/wrh_datapath.sv
// Datapath: limit registers, sector and speed classification, the
// 80-entry counter memory with per-entry valid bits, result register.
// Depends on wrh_pkg.
module wrh_datapath
	import wrh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic [OP_W-1:0]        in_opcode,
	input  logic [DIR_W-1:0]       in_direction,
	input  logic [SPEED_W-1:0]     in_speed,
	input  logic [SEC_W-1:0]       in_read_sector,
	input  logic [CLS_W-1:0]       in_read_speed_bin,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic                   out_accepted,
	output logic [SEC_W-1:0]       out_sector,
	output logic [CLS_W-1:0]       out_speed_class,
	output logic [CNT_OUT_W-1:0]   out_bin_count
);

	// configuration
	logic [SPEED_W-1:0] lim_low_q, lim_mid_q, lim_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_low_q  <= LIMIT_LOW_RST;
			lim_mid_q  <= LIMIT_MID_RST;
			lim_high_q <= LIMIT_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIMIT_LOW:  lim_low_q  <= cfg_data;
				CFG_LIMIT_MID:  lim_mid_q  <= cfg_data;
				CFG_LIMIT_HIGH: lim_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input registers
	logic [OP_W-1:0]    op_q;
	logic [DIR_W-1:0]   dir_q;
	logic [SPEED_W-1:0] spd_q;
	logic [SEC_W-1:0]   rsec_q;
	logic [CLS_W-1:0]   rbin_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_opcode;
			dir_q  <= in_direction;
			spd_q  <= in_speed;
			rsec_q <= in_read_sector;
			rbin_q <= in_read_speed_bin;
		end
	end

	// calc: sector by reciprocal multiply, speed class by first match
	logic              dir_ok;
	logic [PROD_W-1:0] prod;
	logic [CLS_W-1:0]  cls_d;

	assign dir_ok = !dir_q[DIR_W-1] && (dir_q[DIR_W-2:0] < FULL_CIRCLE);
	assign prod   = PROD_W'(dir_q[DIR_W-2:0]) * PROD_W'(SECTOR_RECIP);

	always_comb begin
		if (spd_q == '0)              cls_d = CLS_ZERO;
		else if (spd_q <= lim_low_q)  cls_d = CLS_LOW;
		else if (spd_q <= lim_mid_q)  cls_d = CLS_MID;
		else if (spd_q <= lim_high_q) cls_d = CLS_HIGH;
		else                          cls_d = CLS_ABOVE;
	end

	logic [SEC_W-1:0] sec_q;
	logic [CLS_W-1:0] cls_q;
	logic             add_ok_q;
	logic             rd_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sec_q    <= prod[SECTOR_SHIFT +: SEC_W];
			cls_q    <= cls_d;
			add_ok_q <= (op_q == OP_ADD) && dir_ok;
			rd_ok_q  <= (op_q == OP_READ) && (rbin_q < CLS_W'(NUM_SPEED));
		end
	end

	// fetch: bin address and registered memory read
	logic [BIN_IDX_W-1:0] addr;
	logic [BIN_IDX_W-1:0] addr_q;
	logic                 addr_ok;

	always_comb begin
		if (op_q == OP_READ)
			addr = BIN_IDX_W'({rsec_q, 2'b00}) + BIN_IDX_W'(rsec_q) + BIN_IDX_W'(rbin_q);
		else
			addr = BIN_IDX_W'({sec_q, 2'b00}) + BIN_IDX_W'(sec_q) + BIN_IDX_W'(cls_q);
	end
	assign addr_ok = (addr < BIN_IDX_W'(NUM_BINS));

	logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]    vld_q;
	logic [COUNT_WIDTH-1:0] rd_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			addr_q   <= addr;
			rd_vld_q <= addr_ok && vld_q[addr];
			if (addr_ok) rd_q <= mem[addr];
		end
	end

	// update: saturating increment, write back
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] nxt;

	assign cur = rd_vld_q ? rd_q : '0;
	assign nxt = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);

	always_ff @(posedge clk) begin
		if (cmd.update && add_ok_q) mem[addr_q] <= nxt;
	end

	// never-written or cleared entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.update) begin
			if (op_q == OP_CLEAR) vld_q <= '0;
			else if (add_ok_q)    vld_q[addr_q] <= 1'b1;
		end
	end

	// result register
	logic                 ovld_q;
	logic                 oacc_q;
	logic [SEC_W-1:0]     osec_q;
	logic [CLS_W-1:0]     ocls_q;
	logic [CNT_OUT_W-1:0] ocnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.update) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			oacc_q <= add_ok_q;
			osec_q <= add_ok_q ? sec_q : '0;
			ocls_q <= add_ok_q ? cls_q : '0;
			ocnt_q <= rd_ok_q ? CNT_OUT_W'(cur) : '0;
		end
	end

	assign stat.out_stall  = ovld_q && !m_tready;
	assign m_tvalid        = ovld_q;
	assign out_accepted    = oacc_q;
	assign out_sector      = osec_q;
	assign out_speed_class = ocls_q;
	assign out_bin_count   = ocnt_q;

`include "wind_rose_histogram_assert.svh"

	`WRH_ASSERT_NEXT(a_clear_empties, cmd.update && (op_q == OP_CLEAR), vld_q == '0)
	`WRH_ASSERT_IMPL(a_add_has_no_count, ovld_q && oacc_q, ocnt_q == '0)
	`WRH_ASSERT_IMPL(a_class_in_range, ovld_q && oacc_q, ocls_q < CLS_W'(NUM_SPEED))

endmodule

### hw/rtl/wind_rose_histogram.sv
// Wind rose histogram top level: stream ports, controller and datapath.
// Depends on wrh_pkg, wrh_ctrl, wrh_datapath.
//
// Keeps 16 direction sectors (22.5 degrees each) by 5 speed classes of
// saturating 32-bit counters. Each input transfer is one item: opcode 0
// adds a sample, 1 reads one bin, 2 clears all bins, 3 does nothing.
// Every item yields exactly one result transfer. An item passes through
// the accepting cycle, sector multiply and speed compare, registered
// counter memory read, then saturating write back with the result load.
// The single counter memory port is read then written per item, so
// items are handled one at a time. The result sits in an output register,
// so the next item is accepted while a result waits; a stalled output
// holds the write back step. Clear and reset act at once through one
// valid bit per counter; there is no clearing pass. A sample with a
// negative direction or one of 360 degrees or more is dropped with
// accepted low. Speed classes: zero, <= low limit, <= mid limit,
// <= high limit, above; first match wins. Limits are written through the
// cfg port (index 0 low, 1 mid, 2 high, others ignored); the user must
// write them only while idle, which the block itself does not enforce.
module wind_rose_histogram
	import wrh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// item input
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [13:0] direction, [25:14] speed, [29:26] read_sector,
	// [32:30] read_speed_bin, [39:33] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] opcode
	input  logic [OP_W-1:0]        s_tuser,
	// result output
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [3:0] sector, [6:4] speed_class, [38:7] bin_count, [39] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// [0] accepted
	output logic                   m_tuser
);

	localparam int SPD_LSB  = DIR_W;
	localparam int RSEC_LSB = SPD_LSB + SPEED_W;
	localparam int RBIN_LSB = RSEC_LSB + SEC_W;
	localparam int OUT_USED = SEC_W + CLS_W + CNT_OUT_W;

	cmd_t  cmd;
	stat_t stat;

	logic [SEC_W-1:0]     res_sector;
	logic [CLS_W-1:0]     res_class;
	logic [CNT_OUT_W-1:0] res_count;

	wrh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	wrh_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_opcode         (s_tuser),
		.in_direction      (s_tdata[0 +: DIR_W]),
		.in_speed          (s_tdata[SPD_LSB +: SPEED_W]),
		.in_read_sector    (s_tdata[RSEC_LSB +: SEC_W]),
		.in_read_speed_bin (s_tdata[RBIN_LSB +: CLS_W]),
		.m_tready          (m_tready),
		.m_tvalid          (m_tvalid),
		.out_accepted      (m_tuser),
		.out_sector        (res_sector),
		.out_speed_class   (res_class),
		.out_bin_count     (res_count)
	);

	// pad bits of s_tdata above read_speed_bin are ignored
	assign m_tdata = {{(OUT_TDATA_W - OUT_USED){1'b0}}, res_count, res_class, res_sector};

endmodule

### bench/wind_rose_histogram_test.sv
`timescale 1ns / 100ps
// Self-checking bench for wind_rose_histogram: directed rows, then random phases under
// several limit settings; results checked against typed rows or an in-bench histogram model.
// Depends on wrh_pkg and the wind_rose_histogram RTL.
module wind_rose_histogram_test;
	import wrh_pkg::*;

	// Codes the package leaves unnamed: the spare opcode and the spare register index.
	localparam logic [OP_W-1:0]      OP_NONE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SECTOR_SPAN   = 360;     // sixteenths of a degree per sector
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 255;
	localparam int MAX_IDLE      = 14;
	localparam int DRAIN_CYCLES  = 8;       // slack after the last result
	localparam int CYCLE_LIMIT   = 200000;  // watchdog bound for the whole run
	localparam int NUM_ROWS      = 25;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DIR_W-1:0]   dir;
		logic [SPEED_W-1:0] spd;
		logic [SEC_W-1:0]   rsec;
		logic [CLS_W-1:0]   rbin;
	} rose_item_t;

	typedef struct packed {
		logic                 acc;
		logic [SEC_W-1:0]     sec;
		logic [CLS_W-1:0]     cls;
		logic [CNT_OUT_W-1:0] cnt;
	} rose_result_t;

	// Directed row: the item, then whether the result is typed in here or left to the model.
	typedef struct packed {
		rose_item_t   item;
		logic         typed;
		rose_result_t want;
	} rose_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [OP_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;

	wind_rose_histogram u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Bench copy of the histogram and the speed limits.
	logic [COUNT_WIDTH-1:0] rose_counts [NUM_BINS];
	logic [SPEED_W-1:0] lim_low;
	logic [SPEED_W-1:0] lim_mid;
	logic [SPEED_W-1:0] lim_high;

	rose_result_t awaited_results [$];

	int mismatches;
	int items_sent;
	int results_seen;
	int samples_counted;
	int reads_done;
	int clears_done;
	int cycle_count;
	bit tx_no_idle;
	bit rx_no_idle;

	// Limits at reset are 80 / 240 / 400; typed rows below assume them.
	rose_row_t dir_rows [NUM_ROWS] = '{
		// fresh store reads back zero
		'{'{OP_READ, 14'd0, 12'd0, 4'd0, 3'd0}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_READ, 14'd0, 12'd0, 4'd15, 3'd4}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		// field extremes on a valid sample
		'{'{OP_ADD, 14'd0, 12'd0, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd0, CLS_ZERO, 32'd0}},
		'{'{OP_ADD, 14'd5759, 12'd4095, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd15, CLS_ABOVE, 32'd0}},
		// dropped: full circle, -1, most negative, most positive
		'{'{OP_ADD, 14'd5760, 12'd100, 4'd0, 3'd0}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_ADD, 14'h3fff, 12'd100, 4'd0, 3'd0}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_ADD, 14'h2000, 12'd4095, 4'd15, 3'd7}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_ADD, 14'h1fff, 12'd1, 4'd0, 3'd0}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		// sector edges and each side of every speed limit
		'{'{OP_ADD, 14'd359, 12'd80, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd0, CLS_LOW, 32'd0}},
		'{'{OP_ADD, 14'd360, 12'd81, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd1, CLS_MID, 32'd0}},
		'{'{OP_ADD, 14'd720, 12'd240, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd2, CLS_MID, 32'd0}},
		'{'{OP_ADD, 14'd1080, 12'd241, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd3, CLS_HIGH, 32'd0}},
		'{'{OP_ADD, 14'd1440, 12'd400, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd4, CLS_HIGH, 32'd0}},
		'{'{OP_ADD, 14'd1800, 12'd401, 4'd0, 3'd0}, 1'b1, '{1'b1, 4'd5, CLS_ABOVE, 32'd0}},
		'{'{OP_ADD, 14'd0, 12'd0, 4'd0, 3'd0}, 1'b0, '0},
		'{'{OP_READ, 14'd0, 12'd0, 4'd0, 3'd0}, 1'b0, '0},
		'{'{OP_READ, 14'd0, 12'd0, 4'd15, 3'd4}, 1'b0, '0},
		// read of a speed bin past the last one
		'{'{OP_READ, 14'd0, 12'd0, 4'd0, 3'd5}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_READ, 14'h3fff, 12'hfff, 4'd15, 3'd7}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		// spare opcode does nothing
		'{'{OP_NONE, 14'd100, 12'd50, 4'd15, 3'd4}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_CLEAR, 14'd0, 12'd0, 4'd0, 3'd0}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_READ, 14'd0, 12'd0, 4'd0, 3'd0}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_READ, 14'd0, 12'd0, 4'd4, 3'd3}, 1'b1, '{1'b0, 4'd0, 3'd0, 32'd0}},
		'{'{OP_ADD, 14'd5399, 12'd1, 4'd0, 3'd0}, 1'b0, '0},
		'{'{OP_READ, 14'd0, 12'd0, 4'd14, 3'd1}, 1'b0, '0}
	};

	// Histogram model: applies one item to the bench store, returns the result it yields.
	function automatic rose_result_t predict_rose_item(rose_item_t it);
		rose_result_t r;
		int unsigned idx;
		logic [SEC_W-1:0] sec;
		logic [CLS_W-1:0] cls;
		r = '0;
		case (it.op)
			OP_ADD: begin
				// sign bit set or past the full circle: dropped, store untouched
				if (!it.dir[DIR_W-1] && it.dir[DIR_W-2:0] < FULL_CIRCLE) begin
					sec = SEC_W'(int'(it.dir[DIR_W-2:0]) / SECTOR_SPAN);
					// first match wins, so limits out of order can hide a class
					if (it.spd == '0) cls = CLS_ZERO;
					else if (it.spd <= lim_low) cls = CLS_LOW;
					else if (it.spd <= lim_mid) cls = CLS_MID;
					else if (it.spd <= lim_high) cls = CLS_HIGH;
					else cls = CLS_ABOVE;
					idx = sec * NUM_SPEED + cls;
					if (rose_counts[idx] != '1) rose_counts[idx] = rose_counts[idx] + 1'b1;
					r.acc = 1'b1;
					r.sec = sec;
					r.cls = cls;
				end
			end
			OP_READ: begin
				if (it.rbin < NUM_SPEED) r.cnt = CNT_OUT_W'(rose_counts[it.rsec * NUM_SPEED + it.rbin]);
			end
			OP_CLEAR: begin
				for (int i = 0; i < NUM_BINS; i++) rose_counts[i] = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
	endtask

	// One input transfer after a random gap, if any; the model runs at the accepting edge.
	task automatic send_item(rose_item_t it, logic typed, rose_result_t want);
		rose_result_t pred;
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {7'd0, it.rbin, it.rsec, it.spd, it.dir};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = predict_rose_item(it);
		awaited_results = {awaited_results, (typed ? want : pred)};
		items_sent++;
		if (pred.acc) samples_counted++;
		if (it.op == OP_READ) reads_done++;
		if (it.op == OP_CLEAR) clears_done++;
	endtask

	// Random item, mostly well-formed samples and reads near the interesting edges.
	task automatic send_random_item();
		rose_item_t it;
		logic [SPEED_W-1:0] lim;
		int pick;
		it = '0;
		pick = $urandom_range(0, 99);
		if (pick < 60) it.op = OP_ADD;
		else if (pick < 92) it.op = OP_READ;
		else if (pick < 95) it.op = OP_CLEAR;
		else it.op = OP_NONE;

		pick = $urandom_range(0, 9);
		if (pick == 0) it.dir = DIR_W'($urandom);                      // anything, negatives too
		else if (pick == 1) it.dir = DIR_W'($urandom_range(5760, 8191)); // past full circle
		else if (pick == 2) it.dir = DIR_W'($urandom_range(1, 15) * SECTOR_SPAN - $urandom_range(0, 1));
		else it.dir = DIR_W'($urandom_range(0, 5759));

		pick = $urandom_range(0, 9);
		case (pick) inside
			0: it.spd = '0;
			[1:3]: begin
				// hug one of the limits: just below, on, or just above
				case ($urandom_range(0, 2))
					0: lim = lim_low;
					1: lim = lim_mid;
					default: lim = lim_high;
				endcase
				it.spd = lim + SPEED_W'($urandom_range(0, 2)) - 1'b1;
			end
			4: it.spd = '1;
			default: it.spd = SPEED_W'($urandom);
		endcase

		it.rsec = SEC_W'($urandom);
		it.rbin = ($urandom_range(0, 99) < 85) ? CLS_W'($urandom_range(0, 4))
			: CLS_W'($urandom_range(5, 7));
		send_item(it, 1'b0, '0);
	endtask

	// Let the block empty out: every result in, then a few more cycles.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Three limit writes plus one to the spare index, which must change nothing.
	task automatic write_limits(logic [SPEED_W-1:0] lo, logic [SPEED_W-1:0] mid,
			logic [SPEED_W-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LIMIT_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= CFG_LIMIT_MID;
		cfg_data <= mid;
		@(posedge clk);
		cfg_index <= CFG_LIMIT_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_low = lo;
		lim_mid = mid;
		lim_high = hi;
	endtask

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random stall before each transfer, if any, then field-by-field check
	// against the oldest awaited result.
	initial begin
		rose_result_t want;
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited", m_tdata[38:7], '0);
			end else begin
				want = awaited_results.pop_front();
				if (m_tuser !== want.acc)
					report_mismatch("accepted", 32'(m_tuser), 32'(want.acc));
				if (m_tdata[3:0] !== want.sec)
					report_mismatch("sector", 32'(m_tdata[3:0]), 32'(want.sec));
				if (m_tdata[6:4] !== want.cls)
					report_mismatch("speed_class", 32'(m_tdata[6:4]), 32'(want.cls));
				if (m_tdata[38:7] !== want.cnt)
					report_mismatch("bin_count", m_tdata[38:7], want.cnt);
			end
		end
	end

	// Stimulus: reset, directed rows, then one random phase per limit setting.
	initial begin
		logic [SPEED_W-1:0] phase_lims [RANDOM_PHASES][3];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		samples_counted = 0;
		reads_done = 0;
		clears_done = 0;
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		lim_low = LIMIT_LOW_RST;
		lim_mid = LIMIT_MID_RST;
		lim_high = LIMIT_HIGH_RST;
		for (int i = 0; i < NUM_BINS; i++) rose_counts[i] = '0;

		// all-zero and all-ones extremes, limits out of order, typical, random
		phase_lims[0] = '{12'd0, 12'd0, 12'd0};
		phase_lims[1] = '{12'hfff, 12'hfff, 12'hfff};
		phase_lims[2] = '{12'd300, 12'd100, 12'd2000};
		phase_lims[3] = '{12'd120, 12'd900, 12'd2600};
		phase_lims[4] = '{SPEED_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom)};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_limits(phase_lims[p][0], phase_lims[p][1], phase_lims[p][2]);
			// phases 1 and 3 run the input back to back, 2 and 3 the output
			tx_no_idle = (p == 1 || p == 3);
			rx_no_idle = (p == 2 || p == 3);
			repeat (PHASE_ITEMS) send_random_item();
			drain();
		end

		$display("ran %0d items through %0d limit settings: %0d samples counted, %0d reads, %0d clears",
			items_sent, RANDOM_PHASES + 1, samples_counted, reads_done, clears_done);
		$display("checked %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/wrh_pkg.sv
hw/rtl/wrh_ctrl.sv
hw/rtl/wrh_datapath.sv
hw/rtl/wind_rose_histogram.sv
bench/wind_rose_histogram_test.sv
